>>> design/mbps_pkg.sv
// package for the masked byte pattern scanner
// holds field widths, register indexes and the structs shared by the scanner modules
// no dependencies
package mbps_pkg;

    localparam int DATA_W     = 8;
    localparam int ADDR_W     = 48;
    localparam int IDX_W      = 32;
    localparam int LEN_W      = 5;
    localparam int CARE_W     = 16;
    localparam int PAT_SLOTS  = 16;
    localparam int WORD_W     = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CARE_MASK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_ONLY   = 3'd4;

    localparam logic [IDX_W-1:0] INDEX_MAX = {IDX_W{1'b1}};

    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic [ADDR_W-1:0] byte_address;
        logic              region_first;
        logic              scan_first;
    } item_t;

    typedef struct packed {
        logic [PAT_SLOTS*DATA_W-1:0] pattern;
        logic [CARE_W-1:0]           care_mask;
        logic [LEN_W-1:0]            length;      // already clamped to 1..max pattern
        logic                        stop_on_hit;
    } cfg_t;

    typedef struct packed {
        logic [ADDR_W-1:0] match_address;
        logic [IDX_W-1:0]  match_index;
    } res_t;

    typedef struct packed {
        logic hit;
        logic stopped;
    } status_t;

endpackage

>>> design/mbps_cfg.sv
// configuration registers of the masked byte pattern scanner
// depends on mbps_pkg; clamps the pattern length on write
module mbps_cfg
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    logic [WORD_W-1:0] pat_low_reg;
    logic [WORD_W-1:0] pat_high_reg;
    logic [CARE_W-1:0] care_reg;
    logic [LEN_W-1:0]  len_reg;
    logic              stop_on_hit_reg;
    logic [LEN_W-1:0]  len_clamped;

    always_comb
    begin
        len_clamped = wr_data[LEN_W-1:0];
        if (len_clamped == '0)
        begin
            len_clamped = LEN_W'(1);
        end
        else if (len_clamped > LEN_W'(MAX_PATTERN))
        begin
            len_clamped = LEN_W'(MAX_PATTERN);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg     <= '0;
            pat_high_reg    <= '0;
            care_reg        <= '0;
            len_reg         <= LEN_W'(1);
            stop_on_hit_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_PATTERN_LOW:  pat_low_reg     <= wr_data[WORD_W-1:0];
                REG_PATTERN_HIGH: pat_high_reg    <= wr_data[WORD_W-1:0];
                REG_CARE_MASK:    care_reg        <= wr_data[CARE_W-1:0];
                REG_PATTERN_LEN:  len_reg         <= len_clamped;
                REG_FIRST_ONLY:   stop_on_hit_reg <= wr_data[0];
                default:          ;
            endcase
        end
    end

    assign cfg.pattern     = {pat_high_reg, pat_low_reg};
    assign cfg.care_mask   = care_reg;
    assign cfg.length      = len_reg;
    assign cfg.stop_on_hit = stop_on_hit_reg;

endmodule

>>> design/mbps_match.sv
// byte window, region and scan state, and the parallel masked compare
// depends on mbps_pkg; state advances once per processed byte
module mbps_match
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    input  cfg_t    cfg,
    output res_t    res,
    output status_t status
);

    localparam int CNT_W = $clog2(MAX_PATTERN + 1);

    logic [DATA_W-1:0] win_reg  [MAX_PATTERN];
    logic [DATA_W-1:0] win_next [MAX_PATTERN];
    logic [DATA_W-1:0] sel_byte [MAX_PATTERN];
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_base;
    logic [CNT_W-1:0]  cnt_next;
    logic [IDX_W-1:0]  matches_reg;
    logic [IDX_W-1:0]  matches_base;
    logic [IDX_W-1:0]  matches_next;
    logic              stopped_reg;
    logic              stopped_base;
    logic              stopped_next;
    logic              match_ok;
    logic              hit;

    always_comb
    begin
        cnt_base     = item.region_first ? '0 : cnt_reg;
        matches_base = item.region_first ? '0 : matches_reg;
        stopped_base = item.scan_first ? 1'b0 : stopped_reg;
        cnt_next     = (cnt_base == CNT_W'(MAX_PATTERN)) ? cnt_base : cnt_base + CNT_W'(1);

        win_next[0] = item.data_byte;
        for (int k = 1; k < MAX_PATTERN; k++)
        begin
            win_next[k] = item.region_first ? '0 : win_reg[k-1];
        end

        // pattern byte j lines up with the window entry taken length-1-j bytes ago
        match_ok = 1'b1;
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            sel_byte[j] = '0;
            for (int k = 0; k < MAX_PATTERN; k++)
            begin
                if (LEN_W'(k + j + 1) == cfg.length)
                begin
                    sel_byte[j] = win_next[k];
                end
            end
            if (LEN_W'(j) < cfg.length && cfg.care_mask[j] &&
                sel_byte[j] != cfg.pattern[j*DATA_W +: DATA_W])
            begin
                match_ok = 1'b0;
            end
        end

        hit = !stopped_base && (LEN_W'(cnt_next) >= cfg.length) && match_ok;

        res.match_address = item.byte_address - ADDR_W'(cfg.length) + ADDR_W'(1);
        res.match_index   = matches_base;

        matches_next = matches_base;
        stopped_next = stopped_base;
        if (hit)
        begin
            if (matches_base != INDEX_MAX)
            begin
                matches_next = matches_base + IDX_W'(1);
            end
            stopped_next = stopped_base | cfg.stop_on_hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_PATTERN; k++)
            begin
                win_reg[k] <= '0;
            end
            cnt_reg     <= '0;
            matches_reg <= '0;
            stopped_reg <= 1'b0;
        end
        else if (fire)
        begin
            for (int k = 0; k < MAX_PATTERN; k++)
            begin
                win_reg[k] <= win_next[k];
            end
            cnt_reg     <= cnt_next;
            matches_reg <= matches_next;
            stopped_reg <= stopped_next;
        end
    end

    assign status.hit     = hit;
    assign status.stopped = stopped_reg;

endmodule

>>> design/masked_byte_pattern_scanner.sv
// Masked byte pattern scanner: takes one byte per cycle, sustained, while the output
// side keeps up. Each byte goes into an input register; while it is held there the whole
// window of up to MAX_PATTERN bytes is compared against the pattern in parallel and
// any match is written to the output register as the byte leaves the input register.
// While a match waits in the output register the byte behind it is held in the input
// register, and the input side stalls once both registers are full.
// Configuration is taken every cycle and should only be written while the scanner
// is empty. Top level; depends on mbps_pkg, mbps_cfg and mbps_match.
module masked_byte_pattern_scanner
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [55:0]           s_tdata,   // data_byte[7:0], byte_address[55:8]
    input  logic [1:0]            s_tuser,   // region_first[0], scan_first[1]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [79:0]           m_tdata,   // match_address[47:0], match_index[79:48]
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    item_t   in_reg;
    logic    in_valid_reg;
    res_t    res;
    res_t    res_reg;
    logic    out_valid_reg;
    status_t st;
    logic    advance;
    logic    fire;

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign fire      = in_valid_reg && advance;

    mbps_cfg #(
        .MAX_PATTERN(MAX_PATTERN)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cfg_valid && cfg_ready),
        .wr_index(cfg_index),
        .wr_data (cfg_data),
        .cfg     (cfg)
    );

    mbps_match #(
        .MAX_PATTERN(MAX_PATTERN)
    ) u_match (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (in_reg),
        .cfg   (cfg),
        .res   (res),
        .status(st)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_reg.data_byte    <= s_tdata[7:0];
            in_reg.byte_address <= s_tdata[55:8];
            in_reg.region_first <= s_tuser[0];
            in_reg.scan_first   <= s_tuser[1];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= fire && st.hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && st.hit)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {res_reg.match_index, res_reg.match_address};

    // input side only stalls when both registers are full and the output is held
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a full pipeline");

    // a match in first-only mode stops the scan
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && st.hit && cfg.stop_on_hit) |=> st.stopped)
        else $error("scan not stopped after first-only match");

    // the first match seen on a region start reports index zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && st.hit && in_reg.region_first) |=> (m_tvalid && res_reg.match_index == '0))
        else $error("match index not cleared at region start");

endmodule
